>>> rtl/pid_plant_step_simulator_assert.svh
// Assertion macros for the PID plant step simulator.
`ifndef PID_PLANT_STEP_SIMULATOR_ASSERT_SVH
`define PID_PLANT_STEP_SIMULATOR_ASSERT_SVH

// same-cycle implication
`define PPS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pps: assertion failed");

// next-cycle implication
`define PPS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pps: assertion failed");

`endif

>>> rtl/pps_pkg.sv
// Types and constants shared by the PID plant step simulator.
package pps_pkg;

   localparam int WORD_W  = 32;
   localparam int FRAC_W  = 16;
   localparam int STEP_W  = 16;
   localparam int LIMIT_W = WORD_W - 1;
   localparam int WIDE_W  = 2 * WORD_W;
   localparam int ACC_W   = WIDE_W - FRAC_W + 2;
   localparam int DIV_W   = WORD_W + 1 + FRAC_W;
   localparam int CNT_W   = $clog2(DIV_W + 1);
   localparam int CSR_IDX_W = 3;

   localparam logic signed [WIDE_W-1:0] WORD_MAX = (WIDE_W'(1) <<< (WORD_W - 1)) - 1;
   localparam logic signed [WIDE_W-1:0] WORD_MIN = -WORD_MAX - 1;
   localparam logic [STEP_W-1:0] STEP_MAX = '1;

   localparam logic MODE_STEP    = 1'b0;
   localparam logic MODE_RESTART = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_GOAL     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DT       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_INT_LIM  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_DRV_LIM  = 3'd7;

   localparam logic signed [WORD_W-1:0] GOAL_RESET   = 32'sd5898240;
   localparam logic signed [WORD_W-1:0] GAIN_P_RESET = 32'sd6554;
   localparam logic signed [WORD_W-1:0] GAIN_I_RESET = 32'sd655;
   localparam logic [LIMIT_W-1:0]       DT_RESET     = 31'd65536;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_MUL_EDT,
      ST_INTEG,
      ST_DIV,
      ST_DIFF,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_MUL_T,
      ST_POS,
      ST_WB
   } state_type;

   typedef struct packed {
      logic                     mode;
      logic signed [WORD_W-1:0] start_value;
   } req_type;

   typedef struct packed {
      logic [STEP_W-1:0]        step_index;
      logic signed [WORD_W-1:0] elapsed_time;
      logic signed [WORD_W-1:0] position;
   } rsp_type;

endpackage

>>> rtl/pid_plant_step_simulator.sv
// PID plant step simulator: sequencer, shared multiplier and derivative divider.
//
// One item at a time. A restart item goes straight from idle to the write-back
// state, which loads the output register once it is free; a step item runs the
// 49-iteration restoring divider that forms the derivative and makes five passes
// through the one shared 32x32 multiplier (e*dt, the three gain terms and
// step*dt). The result sits in an output register, so the next item is taken
// while the previous result still waits.

`include "pid_plant_step_simulator_assert.svh"

module pid_plant_step_simulator
   import pps_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata
);

   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
      if (v > WORD_MAX) return WORD_MAX[WORD_W-1:0];
      if (v < WORD_MIN) return WORD_MIN[WORD_W-1:0];
      return v[WORD_W-1:0];
   endfunction

   function automatic logic signed [WORD_W-1:0] clamp_sym(input logic signed [WORD_W-1:0] v,
                                                          input logic [LIMIT_W-1:0] lim);
      logic signed [WORD_W:0] v_x;
      logic signed [WORD_W:0] l_x;
      v_x = {v[WORD_W-1], v};
      l_x = {2'b00, lim};
      if (lim == '0) return v;
      if (v_x > l_x) return $signed({1'b0, lim});
      if (v_x < -l_x) return -$signed({1'b0, lim});
      return v;
   endfunction

   state_type state_ff, state_in;

   logic signed [WORD_W-1:0] goal_ff, goal_in;
   logic signed [WORD_W-1:0] offset_ff, offset_in;
   logic signed [WORD_W-1:0] gain_p_ff, gain_p_in;
   logic signed [WORD_W-1:0] gain_i_ff, gain_i_in;
   logic signed [WORD_W-1:0] gain_d_ff, gain_d_in;
   logic [LIMIT_W-1:0]       dt_ff, dt_in;
   logic [LIMIT_W-1:0]       int_lim_ff, int_lim_in;
   logic [LIMIT_W-1:0]       drv_lim_ff, drv_lim_in;

   logic signed [WORD_W-1:0] pos_ff, pos_in;
   logic signed [WORD_W-1:0] integ_ff, integ_in;
   logic signed [WORD_W-1:0] prev_ff, prev_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic signed [WORD_W-1:0] time_ff, time_in;

   logic signed [WORD_W-1:0] err_ff, err_in;
   logic signed [WORD_W-1:0] diff_ff, diff_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [WIDE_W-1:0] prod_ff, prod_in;

   logic [DIV_W-1:0]         quo_ff, quo_in;
   logic [LIMIT_W-1:0]       rem_ff, rem_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     neg_ff, neg_in;

   rsp_type                  rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic signed [WORD_W-1:0] mul_a, mul_b;
   logic [LIMIT_W-1:0]       dt_val;
   logic [STEP_W-1:0]        step_next;
   logic signed [ACC_W-1:0]  term;
   logic signed [WORD_W:0]   delta;
   logic [WORD_W:0]          delta_mag;
   logic [WORD_W-1:0]        trial;
   logic [WORD_W-1:0]        trial_sub;
   logic                     trial_ge;
   logic signed [WIDE_W-1:0] quo_wide;
   logic signed [WORD_W-1:0] drive;

   assign dt_val    = (dt_ff == '0) ? LIMIT_W'(1) : dt_ff;
   assign step_next = (step_ff == STEP_MAX) ? step_ff : step_ff + 1'b1;
   assign term      = ACC_W'(prod_ff >>> FRAC_W);
   assign delta     = {err_ff[WORD_W-1], err_ff} - {prev_ff[WORD_W-1], prev_ff};
   assign delta_mag = delta[WORD_W] ? $unsigned(-delta) : $unsigned(delta);
   assign trial     = {rem_ff, quo_ff[DIV_W-1]};
   assign trial_ge  = trial >= {1'b0, dt_val};
   assign trial_sub = trial - {1'b0, dt_val};
   assign quo_wide  = $signed(WIDE_W'(quo_ff));
   assign drive     = clamp_sym(sat_word(WIDE_W'(acc_ff)), drv_lim_ff);
   assign prod_in   = mul_a * mul_b;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      goal_in      = goal_ff;
      offset_in    = offset_ff;
      gain_p_in    = gain_p_ff;
      gain_i_in    = gain_i_ff;
      gain_d_in    = gain_d_ff;
      dt_in        = dt_ff;
      int_lim_in   = int_lim_ff;
      drv_lim_in   = drv_lim_ff;
      pos_in       = pos_ff;
      integ_in     = integ_ff;
      prev_in      = prev_ff;
      step_in      = step_ff;
      time_in      = time_ff;
      err_in       = err_ff;
      diff_in      = diff_ff;
      acc_in       = acc_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mul_a        = '0;
      mul_b        = '0;

      if (csr_we) begin
         case (csr_index)
            CSR_GOAL: begin
               goal_in = $signed(csr_wdata);
            end
            CSR_OFFSET: begin
               offset_in = $signed(csr_wdata);
            end
            CSR_GAIN_P: begin
               gain_p_in = $signed(csr_wdata);
            end
            CSR_GAIN_I: begin
               gain_i_in = $signed(csr_wdata);
            end
            CSR_GAIN_D: begin
               gain_d_in = $signed(csr_wdata);
            end
            CSR_DT: begin
               dt_in = csr_wdata[LIMIT_W-1:0];
            end
            CSR_INT_LIM: begin
               int_lim_in = csr_wdata[LIMIT_W-1:0];
            end
            CSR_DRV_LIM: begin
               drv_lim_in = csr_wdata[LIMIT_W-1:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.mode == MODE_RESTART) begin
                  pos_in   = req_data.start_value;
                  integ_in = '0;
                  prev_in  = '0;
                  step_in  = '0;
                  time_in  = '0;
                  state_in = ST_WB;
               end else begin
                  state_in = ST_ERR;
               end
            end
         end
         ST_ERR: begin
            err_in   = sat_word(WIDE_W'(goal_ff) - WIDE_W'(pos_ff));
            state_in = ST_MUL_EDT;
         end
         ST_MUL_EDT: begin
            mul_a    = err_ff;
            mul_b    = $signed({1'b0, dt_val});
            state_in = ST_INTEG;
         end
         ST_INTEG: begin
            integ_in = sat_word(WIDE_W'(integ_ff) + (prod_ff >>> FRAC_W));
            neg_in   = delta[WORD_W];
            quo_in   = {delta_mag, FRAC_W'(0)};
            rem_in   = '0;
            cnt_in   = CNT_W'(DIV_W);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = trial_ge ? trial_sub[LIMIT_W-1:0] : trial[LIMIT_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], trial_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            diff_in  = sat_word(neg_ff ? -quo_wide : quo_wide);
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            mul_a    = gain_p_ff;
            mul_b    = err_ff;
            state_in = ST_MUL_I;
         end
         ST_MUL_I: begin
            mul_a    = gain_i_ff;
            mul_b    = integ_ff;
            acc_in   = term;
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            mul_a    = gain_d_ff;
            mul_b    = diff_ff;
            acc_in   = acc_ff + term;
            state_in = ST_MUL_T;
         end
         ST_MUL_T: begin
            mul_a    = $signed({{(WORD_W-STEP_W){1'b0}}, step_next});
            mul_b    = $signed({1'b0, dt_val});
            acc_in   = acc_ff + term;
            state_in = ST_POS;
         end
         ST_POS: begin
            pos_in   = sat_word(WIDE_W'(pos_ff) + WIDE_W'(drive) - WIDE_W'(offset_ff));
            integ_in = clamp_sym(integ_ff, int_lim_ff);
            prev_in  = err_ff;
            step_in  = step_next;
            time_in  = sat_word(prod_ff);
            state_in = ST_WB;
         end
         ST_WB: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.step_index   = step_ff;
               rsp_in.elapsed_time = time_ff;
               rsp_in.position     = pos_ff;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         goal_ff      <= GOAL_RESET;
         offset_ff    <= '0;
         gain_p_ff    <= GAIN_P_RESET;
         gain_i_ff    <= GAIN_I_RESET;
         gain_d_ff    <= '0;
         dt_ff        <= DT_RESET;
         int_lim_ff   <= '0;
         drv_lim_ff   <= '0;
         pos_ff       <= '0;
         integ_ff     <= '0;
         prev_ff      <= '0;
         step_ff      <= '0;
         time_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         goal_ff      <= goal_in;
         offset_ff    <= offset_in;
         gain_p_ff    <= gain_p_in;
         gain_i_ff    <= gain_i_in;
         gain_d_ff    <= gain_d_in;
         dt_ff        <= dt_in;
         int_lim_ff   <= int_lim_in;
         drv_lim_ff   <= drv_lim_in;
         pos_ff       <= pos_in;
         integ_ff     <= integ_in;
         prev_ff      <= prev_in;
         step_ff      <= step_in;
         time_ff      <= time_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff  <= err_in;
      diff_ff <= diff_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      rsp_ff  <= rsp_in;
   end

   `PPS_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `PPS_ASSERT_NXT(a_wb_holds, clock, reset,
                   (state_ff == ST_WB) && rsp_valid_ff && !rsp_ready, state_ff == ST_WB)
   `PPS_ASSERT_NXT(a_wb_delivers, clock, reset,
                   (state_ff == ST_WB) && (!rsp_valid_ff || rsp_ready), rsp_valid_ff)
   `PPS_ASSERT_IMP(a_div_count, clock, reset, state_ff == ST_DIV, cnt_ff != '0)

endmodule

>>> tb/pid_plant_step_simulator_tb.sv
// Self-checking testbench for the PID plant step simulator: directed table, random runs.
module pid_plant_step_simulator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pps_pkg::*;

   localparam int CYCLE_LIMIT   = 400_000;
   localparam int RESET_CYCLES  = 7;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 108;
   localparam int HOLD_AT       = 130;
   localparam int HOLD_LEN      = 600;
   localparam int DRAIN_TAIL    = 80;
   localparam int REPORT_MAX    = 10;
   localparam int NUM_REGS      = 1 << CSR_IDX_W;

   localparam longint SAT_HI = 64'sh7FFF_FFFF;
   localparam longint SAT_LO = -SAT_HI - 1;

   typedef enum {ROW_ITEM, ROW_REG} row_kind_type;
   typedef enum {SET_TAME, SET_RAW, SET_EXTREME} setting_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [WORD_W-1:0]     word;
      logic                  mode;
      bit                    fixed;
      rsp_type               want;
   } plan_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]    csr_wdata = '0;

   // shadow registers and plant state
   longint tgt, drift, kp, ki, kd, dt_reg, ilim, dlim;
   longint pos_s, integ_s, prev_e, elapsed_s;
   logic [STEP_W-1:0] steps_s;

   rsp_type      pending_rsp[$];
   plan_row_type directed_plan[$];
   int           mismatch_count = 0;
   int           rsp_seen = 0;
   int           hold_left = 0;
   int           send_gap_pct = 0;
   int           rsp_gap_pct = 0;
   int           cycle_count;

   setting_kind_type phase_kind[RANDOM_PHASES] =
      '{SET_TAME, SET_RAW, SET_TAME, SET_EXTREME, SET_TAME, SET_RAW};

   pid_plant_step_simulator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic longint clip32(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
   endfunction

   function automatic longint limit_sym(longint v, longint lim);
      if (lim == 0) return v;
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // Q16.16 product, floor rounding
   function automatic longint fmul(longint a, longint b);
      return (a * b) >>> FRAC_W;
   endfunction

   function automatic void reset_model();
      tgt       = longint'(GOAL_RESET);
      drift     = 0;
      kp        = longint'(GAIN_P_RESET);
      ki        = longint'(GAIN_I_RESET);
      kd        = 0;
      dt_reg    = longint'(DT_RESET);
      ilim      = 0;
      dlim      = 0;
      pos_s     = 0;
      integ_s   = 0;
      prev_e    = 0;
      elapsed_s = 0;
      steps_s   = '0;
   endfunction

   function automatic void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] word);
      case (idx)
         CSR_GOAL:    tgt    = longint'($signed(word));
         CSR_OFFSET:  drift  = longint'($signed(word));
         CSR_GAIN_P:  kp     = longint'($signed(word));
         CSR_GAIN_I:  ki     = longint'($signed(word));
         CSR_GAIN_D:  kd     = longint'($signed(word));
         CSR_DT:      dt_reg = longint'(word[LIMIT_W-1:0]);
         CSR_INT_LIM: ilim   = longint'(word[LIMIT_W-1:0]);
         CSR_DRV_LIM: dlim   = longint'(word[LIMIT_W-1:0]);
         default: ;
      endcase
   endfunction

   function automatic rsp_type plant_step(req_type it);
      longint  dt, e, drive;
      rsp_type r;
      dt = (dt_reg == 0) ? 1 : dt_reg;
      if (it.mode == MODE_RESTART) begin
         pos_s     = longint'($signed(it.start_value));
         integ_s   = 0;
         prev_e    = 0;
         steps_s   = '0;
         elapsed_s = 0;
      end else begin
         e       = clip32(tgt - pos_s);
         integ_s = clip32(integ_s + fmul(e, dt));
         drive   = clip32(fmul(kp, e) + fmul(ki, integ_s)
                          + fmul(kd, clip32(((e - prev_e) <<< FRAC_W) / dt)));
         drive   = limit_sym(drive, dlim);
         pos_s   = clip32(pos_s + drive - drift);
         integ_s = limit_sym(integ_s, ilim);
         prev_e  = e;
         if (steps_s != STEP_MAX) steps_s++;
         elapsed_s = clip32(longint'(steps_s) * dt);
      end
      r.step_index   = steps_s;
      r.elapsed_time = elapsed_s[WORD_W-1:0];
      r.position     = pos_s[WORD_W-1:0];
      return r;
   endfunction

   function automatic void plan_item(logic mode, logic [WORD_W-1:0] word,
                                     bit fixed = 1'b0, rsp_type want = '0);
      plan_row_type row;
      row.kind  = ROW_ITEM;
      row.idx   = '0;
      row.word  = word;
      row.mode  = mode;
      row.fixed = fixed;
      row.want  = want;
      directed_plan.push_back(row);
   endfunction

   function automatic void plan_reg(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] word);
      plan_row_type row;
      row.kind  = ROW_REG;
      row.idx   = idx;
      row.word  = word;
      row.mode  = MODE_STEP;
      row.fixed = 1'b0;
      row.want  = '0;
      directed_plan.push_back(row);
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] word);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= word;
      apply_reg(idx, word);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   task automatic offer_item(req_type it, bit fixed, rsp_type want);
      rsp_type predicted;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = plant_step(it);
      pending_rsp.push_back(fixed ? want : predicted);
   endtask

   task automatic load_setting(setting_kind_type kind);
      logic [WORD_W-1:0]    word;
      logic [CSR_IDX_W-1:0] idx;
      for (int i = 0; i < NUM_REGS; i++) begin
         idx = CSR_IDX_W'(i);
         if (kind == SET_RAW) begin
            word = $urandom;
         end else if (kind == SET_EXTREME) begin
            case ($urandom_range(4))
               0: word = '0;
               1: word = 32'h0000_0001;
               2: word = 32'h7FFF_FFFF;
               3: word = 32'h8000_0000;
               default: word = 32'hFFFF_FFFF;
            endcase
         end else begin
            case (idx)
               CSR_GOAL:    word = $urandom_range(32'h0200_0000) - 32'h0100_0000;
               CSR_OFFSET:  word = $urandom_range(8192) - 4096;
               CSR_GAIN_P:  word = $urandom_range(65536);
               CSR_GAIN_I:  word = $urandom_range(8192);
               CSR_GAIN_D:  word = $urandom_range(16384);
               CSR_DT:      word = $urandom_range(131072, 4096);
               CSR_INT_LIM: word = ($urandom_range(3) == 0) ? '0
                                   : $urandom_range(32'h0400_0000, 1);
               default:     word = ($urandom_range(2) == 0) ? '0
                                   : $urandom_range(32'h0040_0000, 1);
            endcase
            // upper bit of the 31-bit registers must be dropped
            if (idx == CSR_DT || idx == CSR_INT_LIM || idx == CSR_DRV_LIM)
               word[WORD_W-1] = 1'($urandom_range(1));
         end
         write_reg(idx, word);
      end
   endtask

   // result side: ready pattern, long hold-off, checking
   initial begin
      rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("unexpected item: step %0d elapsed %0d position %0d",
                           rsp_data.step_index, rsp_data.elapsed_time, rsp_data.position);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.step_index !== want.step_index
                   || rsp_data.elapsed_time !== want.elapsed_time
                   || rsp_data.position !== want.position) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX)
                     $display("mismatch: want step %0d elapsed %0d position %0d, got %0d %0d %0d",
                              want.step_index, want.elapsed_time, want.position,
                              rsp_data.step_index, rsp_data.elapsed_time, rsp_data.position);
               end
            end
            rsp_seen++;
            if (rsp_seen == HOLD_AT) hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_gap_pct);
         end
      end
   end

   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("pid_plant_step_simulator verification failed");
      $finish;
   end

   initial begin
      req_type     it;
      logic [WORD_W-1:0] goal_word;

      reset_model();

      // from reset: 90.0 goal, kp 0.1, ki 0.01, dt 1.0
      plan_item(MODE_STEP, 32'h1234_5678, 1'b1, rsp_type'{16'd1, 32'sd65536, 32'sd648810});
      plan_item(MODE_STEP, 32'hEDCB_A987);
      plan_item(MODE_RESTART, 32'h8000_0000, 1'b1, rsp_type'{'0, '0, 32'h8000_0000});
      plan_item(MODE_STEP, '0);
      plan_item(MODE_RESTART, 32'h7FFF_FFFF, 1'b1, rsp_type'{'0, '0, 32'h7FFF_FFFF});
      plan_item(MODE_STEP, '1);
      plan_reg(CSR_GOAL, 32'h7FFF_FFFF);
      plan_reg(CSR_OFFSET, 32'h8000_0000);
      plan_item(MODE_RESTART, '0, 1'b1, rsp_type'{'0, '0, '0});
      plan_item(MODE_STEP, '0);
      plan_item(MODE_STEP, '0);
      // zero dt behaves as one LSB
      plan_reg(CSR_GAIN_P, 32'h7FFF_FFFF);
      plan_reg(CSR_GAIN_I, 32'h8000_0000);
      plan_reg(CSR_GAIN_D, 32'h7FFF_FFFF);
      plan_reg(CSR_DT, '0);
      plan_reg(CSR_INT_LIM, 32'h7FFF_FFFF);
      plan_reg(CSR_DRV_LIM, 32'h0000_0001);
      plan_item(MODE_RESTART, 32'hFFFF_FFFF, 1'b1, rsp_type'{'0, '0, 32'hFFFF_FFFF});
      plan_item(MODE_STEP, '0);
      plan_item(MODE_STEP, '0);
      plan_item(MODE_STEP, '0);
      // maximum dt: elapsed time saturates on the second step
      plan_reg(CSR_GOAL, 32'h8000_0000);
      plan_reg(CSR_OFFSET, 32'h7FFF_FFFF);
      plan_reg(CSR_GAIN_D, 32'h8000_0000);
      plan_reg(CSR_DT, 32'hFFFF_FFFF);
      plan_reg(CSR_INT_LIM, 32'h0000_0001);
      plan_reg(CSR_DRV_LIM, '0);
      plan_item(MODE_RESTART, 32'h0000_0001, 1'b1, rsp_type'{'0, '0, 32'h0000_0001});
      plan_item(MODE_STEP, '0);
      plan_item(MODE_STEP, '0);
      plan_item(MODE_STEP, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      send_gap_pct = 17;
      rsp_gap_pct  = 47;
      foreach (directed_plan[n]) begin
         if (directed_plan[n].kind == ROW_REG) begin
            wait_drained();
            write_reg(directed_plan[n].idx, directed_plan[n].word);
         end else begin
            it.mode        = directed_plan[n].mode;
            it.start_value = directed_plan[n].word;
            offer_item(it, directed_plan[n].fixed, directed_plan[n].want);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drained();
         load_setting(phase_kind[phase]);
         if (phase < 2) begin
            send_gap_pct = 17;
            rsp_gap_pct  = 47;
         end else if (phase < 4) begin
            send_gap_pct = 47;
            rsp_gap_pct  = 17;
         end else begin
            send_gap_pct = 0;
            rsp_gap_pct  = 0;
         end
         goal_word = tgt[WORD_W-1:0];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 1 && n == PHASE_ITEMS / 2) wait_drained();
            it.mode = (n == 0 || $urandom_range(19) == 0) ? MODE_RESTART : MODE_STEP;
            if ($urandom_range(2) == 0)
               it.start_value = $urandom;
            else
               it.start_value = goal_word + $urandom_range(32'h0010_0000) - 32'h0008_0000;
            offer_item(it, 1'b0, '0);
         end
      end

      wait_drained();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0)
         $display("pid_plant_step_simulator verification clean");
      else
         $display("pid_plant_step_simulator verification failed");
      $finish;
   end

endmodule
